// File: design/cbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, constants and controller/datapath interface structs for the
// cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // storage and field widths
  localparam int RAM_BYTES_DEF  = 131072;
  localparam int ROM_BANK_BYTES = 16384;
  localparam int ROM_OFF_W      = $clog2(ROM_BANK_BYTES);
  localparam int RAM_OFF_W      = 13;
  localparam int ADDR_W         = 15;
  localparam int DATA_W         = 8;
  localparam int ROM_ADDR_W     = 23;
  localparam int BANK_W         = 9;
  localparam int RAM_SEL_W      = 8;
  localparam int RAM_LOC_W      = RAM_SEL_W + RAM_OFF_W;
  localparam int MBC2_OFF_W     = 9;

  // remainder unit widths
  localparam int QUOT_W = 13;
  localparam int REM_W  = 18;

  // config register widths
  localparam int KIND_W    = 3;
  localparam int ROM_TOT_W = 10;
  localparam int RAM_TOT_W = 5;
  localparam int RAM_LEN_W = 18;

  // mapper kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MBC1 = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MBC2 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MBC3 = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MBC5 = 3'd4;

  // register indexes
  localparam logic [1:0] REG_MAPPER_KIND  = 2'd0;
  localparam logic [1:0] REG_ROM_BANK_TOT = 2'd1;
  localparam logic [1:0] REG_RAM_BANK_TOT = 2'd2;
  localparam logic [1:0] REG_RAM_BYTE_LEN = 2'd3;

  // rom area write regions, address bits 14:13
  localparam logic [1:0] REGION_ENABLE = 2'd0;
  localparam logic [1:0] REGION_ROMSEL = 2'd1;
  localparam logic [1:0] REGION_RAMSEL = 2'd2;
  localparam logic [1:0] REGION_MODE   = 2'd3;

  localparam logic [3:0]        RAM_ENABLE_KEY = 4'hA;
  localparam logic [DATA_W-1:0] NIBBLE_FILL    = 8'hF0;
  localparam logic [DATA_W-1:0] ABSENT_BYTE    = 8'hFF;

  typedef enum logic [1:0] {
    CMD_ROM_READ  = 2'd0,
    CMD_ROM_WRITE = 2'd1,
    CMD_RAM_READ  = 2'd2,
    CMD_RAM_WRITE = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [KIND_W-1:0]    mapper_kind;
    logic [ROM_TOT_W-1:0] rom_bank_total;
    logic [RAM_TOT_W-1:0] ram_bank_total;
    logic [RAM_LEN_W-1:0] ram_byte_length;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic div_start;
    logic apply;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } dp_status_t;

endpackage

// File: design/cbm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_divider
// Restoring remainder unit, one dividend bit per cycle. A zero divisor
// returns the dividend unchanged.
// ----------------------------------------------------------------------------
module cbm_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cbm_pkg::QUOT_W-1:0] dividend_i,
  input  logic [cbm_pkg::REM_W-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [cbm_pkg::REM_W-1:0]  rem_o
);
  import cbm_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

  logic                busy_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [QUOT_W-1:0]   shift_q;
  logic [REM_W-1:0]    div_q;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [REM_W:0]      trial;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_q, shift_q[QUOT_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = REM_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[REM_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      shift_q <= dividend_i;
      div_q   <= divisor_i;
    end else if (busy_q) begin
      rem_q   <= rem_d;
      shift_q <= {shift_q[QUOT_W-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// File: design/cbm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_datapath
// Request registers, bank select state, remainder unit, save ram and the
// result register of the cartridge bank mapper.
// ----------------------------------------------------------------------------
module cbm_datapath #(
  parameter int RAM_BYTES = cbm_pkg::RAM_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbm_pkg::cfg_t                 cfg_i,
  input  cbm_pkg::dp_cmd_t              cmd_i,
  output cbm_pkg::dp_status_t           status_o,
  input  logic [1:0]                    command_i,
  input  logic [cbm_pkg::ADDR_W-1:0]    address_i,
  input  logic [cbm_pkg::DATA_W-1:0]    write_data_i,
  output logic [cbm_pkg::DATA_W-1:0]    read_data_o,
  output logic [cbm_pkg::ROM_ADDR_W-1:0] rom_address_o,
  output logic                          rom_fetch_o
);
  import cbm_pkg::*;

  localparam int RAM_AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
  localparam logic [RAM_LOC_W-1:0] RAM_CAP = RAM_LOC_W'(RAM_BYTES);

  // request registers
  cmd_e              cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;

  // mapper state
  logic [BANK_W-1:0]    rom_sel_q, rom_sel_d;
  logic [RAM_SEL_W-1:0] ram_sel_q, ram_sel_d;
  logic                 ram_locked_q, ram_locked_d;
  logic                 bank_mode_q, bank_mode_d;

  // remainder unit
  logic              need_div;
  logic [QUOT_W-1:0] dividend;
  logic [REM_W-1:0]  divisor;
  logic              div_busy;
  logic [REM_W-1:0]  rem;

  logic [1:0]           region;
  logic [RAM_OFF_W-1:0] win_off;
  logic [6:0]           mbc1_bank;
  logic                 kind_known;
  logic [BANK_W-1:0]    rom_bank;
  logic [ROM_ADDR_W-1:0] rom_addr;
  logic [BANK_W-1:0]    mbc3_bank;

  // save ram lookup
  logic [RAM_LOC_W-1:0] loc;
  logic [RAM_LOC_W-1:0] limit;
  logic [RAM_LOC_W-1:0] len_ext;
  logic                 found;
  logic                 skip_limit;
  logic                 hit;
  logic [RAM_AW-1:0]    ram_idx;
  logic [DATA_W-1:0]    ram_wdata;

  logic [DATA_W-1:0] save_ram [RAM_BYTES];
  logic [DATA_W-1:0] ram_rd_q;

  // result staging and output
  logic [ROM_ADDR_W-1:0] res_rom_addr_q;
  logic                  res_fetch_q;
  logic                  res_ram_rd_q;
  logic                  res_hit_q;
  logic [DATA_W-1:0]     out_read_data_q;
  logic [ROM_ADDR_W-1:0] out_rom_addr_q;
  logic                  out_fetch_q;

  assign region     = addr_q[ADDR_W-1 -: 2];
  assign win_off    = addr_q[RAM_OFF_W-1:0];
  assign kind_known = (cfg_i.mapper_kind != KIND_NONE) && (cfg_i.mapper_kind <= KIND_MBC5);

  // mbc1 bank after mode masking, bank zero maps to one
  always_comb begin
    mbc1_bank = bank_mode_q ? {2'b00, rom_sel_q[4:0]} : rom_sel_q[6:0];
    if (mbc1_bank == 7'd0) begin
      mbc1_bank = 7'd1;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q   <= cmd_e'(command_i);
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
  end

  // remainder operand selection
  always_comb begin
    need_div = 1'b0;
    dividend = '0;
    divisor  = '0;
    unique case (cmd_q)
      CMD_ROM_READ: begin
        if (addr_q[ADDR_W-1]) begin
          if (cfg_i.mapper_kind == KIND_MBC1) begin
            need_div = 1'b1;
            dividend = QUOT_W'(mbc1_bank);
            divisor  = REM_W'(cfg_i.rom_bank_total);
          end else if (cfg_i.mapper_kind == KIND_MBC5) begin
            need_div = 1'b1;
            dividend = QUOT_W'(rom_sel_q);
            divisor  = REM_W'(cfg_i.rom_bank_total);
          end
        end
      end
      CMD_ROM_WRITE: begin
        if (cfg_i.mapper_kind == KIND_MBC1 && region == REGION_RAMSEL) begin
          need_div = (cfg_i.ram_bank_total != '0);
          dividend = QUOT_W'(wdata_q[1:0]);
          divisor  = REM_W'(cfg_i.ram_bank_total);
        end else if (cfg_i.mapper_kind == KIND_MBC3 && region == REGION_ROMSEL) begin
          need_div = 1'b1;
          dividend = QUOT_W'(wdata_q[6:0]);
          divisor  = REM_W'(cfg_i.rom_bank_total);
        end else if (cfg_i.mapper_kind == KIND_MBC5 && region == REGION_RAMSEL) begin
          need_div = (cfg_i.ram_bank_total != '0);
          dividend = QUOT_W'(wdata_q[3:0]);
          divisor  = REM_W'(cfg_i.ram_bank_total);
        end
      end
      default: begin
        if (cfg_i.mapper_kind == KIND_MBC1 && cfg_i.ram_bank_total == RAM_TOT_W'(1)) begin
          need_div = (cfg_i.ram_byte_length != '0);
          dividend = QUOT_W'(win_off);
          divisor  = cfg_i.ram_byte_length;
        end else if (cfg_i.mapper_kind == KIND_MBC3 && ram_sel_q[RAM_SEL_W-1:2] == '0) begin
          need_div = (cfg_i.ram_bank_total != '0);
          dividend = QUOT_W'(ram_sel_q[1:0]);
          divisor  = REM_W'(cfg_i.ram_bank_total);
        end
      end
    endcase
  end

  cbm_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .rem_o      (rem)
  );

  assign status_o.need_div = need_div;
  assign status_o.div_busy = div_busy;

  // rom address translation
  always_comb begin
    if (cfg_i.mapper_kind == KIND_MBC1 || cfg_i.mapper_kind == KIND_MBC5) begin
      rom_bank = rem[BANK_W-1:0];
    end else begin
      rom_bank = rom_sel_q;
    end
    if (!addr_q[ADDR_W-1] || !kind_known) begin
      rom_addr = ROM_ADDR_W'(addr_q);
    end else begin
      rom_addr = {rom_bank, addr_q[ROM_OFF_W-1:0]};
    end
  end

  // mbc3 rom bank, zero maps to one
  always_comb begin
    mbc3_bank = rem[BANK_W-1:0];
    if (mbc3_bank == '0) begin
      mbc3_bank = BANK_W'(1);
    end
  end

  // bank register writes
  always_comb begin
    rom_sel_d    = rom_sel_q;
    ram_sel_d    = ram_sel_q;
    ram_locked_d = ram_locked_q;
    bank_mode_d  = bank_mode_q;
    if (cmd_q == CMD_ROM_WRITE && kind_known) begin
      if (region == REGION_ENABLE) begin
        ram_locked_d = (wdata_q[3:0] != RAM_ENABLE_KEY);
      end else begin
        unique case (cfg_i.mapper_kind)
          KIND_MBC1: begin
            unique case (region)
              REGION_ROMSEL: rom_sel_d = {rom_sel_q[BANK_W-1:5], wdata_q[4:0]};
              REGION_RAMSEL: begin
                rom_sel_d = {2'b00, wdata_q[1:0], rom_sel_q[4:0]};
                if (cfg_i.ram_bank_total != '0) begin
                  ram_sel_d = rem[RAM_SEL_W-1:0];
                end
              end
              default: bank_mode_d = wdata_q[0];
            endcase
          end
          KIND_MBC2: begin
            if (region == REGION_ROMSEL) begin
              if (wdata_q[3:0] == 4'd0) begin
                rom_sel_d = BANK_W'(1);
              end else begin
                rom_sel_d = BANK_W'(wdata_q[3:0]);
              end
            end
          end
          KIND_MBC3: begin
            if (region == REGION_ROMSEL) begin
              rom_sel_d = mbc3_bank;
            end else if (region == REGION_RAMSEL) begin
              ram_sel_d = wdata_q;
            end
          end
          default: begin
            if (region == REGION_ROMSEL) begin
              if (!addr_q[12]) begin
                rom_sel_d = {rom_sel_q[BANK_W-1], wdata_q};
              end else begin
                rom_sel_d = {wdata_q[0], rom_sel_q[BANK_W-2:0]};
              end
            end else if (region == REGION_RAMSEL && cfg_i.ram_bank_total != '0) begin
              ram_sel_d = rem[RAM_SEL_W-1:0];
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_sel_q    <= BANK_W'(1);
      ram_sel_q    <= '0;
      ram_locked_q <= 1'b1;
      bank_mode_q  <= 1'b0;
    end else if (cmd_i.apply) begin
      rom_sel_q    <= rom_sel_d;
      ram_sel_q    <= ram_sel_d;
      ram_locked_q <= ram_locked_d;
      bank_mode_q  <= bank_mode_d;
    end
  end

  // save ram location and bounds
  always_comb begin
    loc        = '0;
    found      = 1'b0;
    skip_limit = 1'b0;
    unique case (cfg_i.mapper_kind)
      KIND_MBC1: begin
        if (cfg_i.ram_bank_total == RAM_TOT_W'(1)) begin
          found = (cfg_i.ram_byte_length != '0);
          loc   = RAM_LOC_W'(rem);
        end else if (cfg_i.ram_bank_total != '0) begin
          found = 1'b1;
          loc   = RAM_LOC_W'({(bank_mode_q ? ram_sel_q[1:0] : 2'b00), win_off});
        end
      end
      KIND_MBC2: begin
        found      = 1'b1;
        skip_limit = 1'b1;
        loc        = RAM_LOC_W'(addr_q[MBC2_OFF_W-1:0]);
      end
      KIND_MBC3: begin
        found = (ram_sel_q[RAM_SEL_W-1:2] == '0) && (cfg_i.ram_bank_total != '0);
        loc   = RAM_LOC_W'({rem[1:0], win_off});
      end
      KIND_MBC5: begin
        found = (cfg_i.ram_bank_total != '0);
        loc   = {ram_sel_q, win_off};
      end
      default: begin
        found = 1'b0;
      end
    endcase
    len_ext = RAM_LOC_W'(cfg_i.ram_byte_length);
    limit   = (len_ext > RAM_CAP) ? RAM_CAP : len_ext;
    hit     = found && (skip_limit || (loc < limit));
  end

  assign ram_idx   = loc[RAM_AW-1:0];
  assign ram_wdata = (cfg_i.mapper_kind == KIND_MBC2) ? (wdata_q | NIBBLE_FILL) : wdata_q;

  // save ram port
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && cmd_q == CMD_RAM_WRITE && !ram_locked_q && hit) begin
      save_ram[ram_idx] <= ram_wdata;
    end
    if (cmd_i.apply && cmd_q == CMD_RAM_READ) begin
      ram_rd_q <= save_ram[ram_idx];
    end
  end

  // result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      res_rom_addr_q <= (cmd_q == CMD_ROM_READ) ? rom_addr : '0;
      res_fetch_q    <= (cmd_q == CMD_ROM_READ);
      res_ram_rd_q   <= (cmd_q == CMD_RAM_READ);
      res_hit_q      <= hit;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (res_ram_rd_q) begin
        out_read_data_q <= res_hit_q ? ram_rd_q : ABSENT_BYTE;
      end else begin
        out_read_data_q <= '0;
      end
      out_rom_addr_q <= res_rom_addr_q;
      out_fetch_q    <= res_fetch_q;
    end
  end

  assign read_data_o   = out_read_data_q;
  assign rom_address_o = out_rom_addr_q;
  assign rom_fetch_o   = out_fetch_q;

endmodule

// File: design/cbm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_ctrl
// Sequencer of the cartridge bank mapper: takes a request, runs the
// remainder unit when needed, applies the access and hands over the result.
// ----------------------------------------------------------------------------
module cbm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  cbm_pkg::dp_status_t status_i,
  output cbm_pkg::dp_cmd_t    cmd_o
);
  import cbm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_APPLY,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.div_start = status_i.need_div;
        state_d         = status_i.need_div ? ST_DIV : ST_APPLY;
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.load || (out_valid_q && out_stall_i);
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: design/cartridge_bank_mapper.sv
`timescale 1ns / 1ps
// A request is latched and prepared, then runs the remainder unit when a
// bank or offset remainder is needed (the one-bit-per-cycle remainder unit
// runs 13 steps), is applied and is loaded into the output register. The
// next request is stalled until then and may enter while a result waits in
// the output register. Reset clears the bank selects (rom bank 1), locks the
// save ram and restores the config registers; save ram contents are kept.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Top level: config register port, sequencer and datapath of the
// cartridge bank mapper.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper #(
  parameter int RAM_BYTES = cbm_pkg::RAM_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     command_i,
  input  logic [cbm_pkg::ADDR_W-1:0]     address_i,
  input  logic [cbm_pkg::DATA_W-1:0]     write_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cbm_pkg::DATA_W-1:0]     read_data_o,
  output logic [cbm_pkg::ROM_ADDR_W-1:0] rom_address_o,
  output logic                           rom_fetch_o,
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import cbm_pkg::*;

  logic [KIND_W-1:0]    mapper_kind_q;
  logic [ROM_TOT_W-1:0] rom_bank_total_q;
  logic [RAM_TOT_W-1:0] ram_bank_total_q;
  logic [RAM_LEN_W-1:0] ram_byte_length_q;
  logic [1:0]           reg_idx;
  logic                 cfg_wr;
  cfg_t                 cfg;
  dp_cmd_t              dp_cmd;
  dp_status_t           dp_status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapper_kind_q     <= KIND_NONE;
      rom_bank_total_q  <= ROM_TOT_W'(2);
      ram_bank_total_q  <= '0;
      ram_byte_length_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAPPER_KIND:  mapper_kind_q     <= pwdata[KIND_W-1:0];
        REG_ROM_BANK_TOT: rom_bank_total_q  <= pwdata[ROM_TOT_W-1:0];
        REG_RAM_BANK_TOT: ram_bank_total_q  <= pwdata[RAM_TOT_W-1:0];
        default:          ram_byte_length_q <= pwdata[RAM_LEN_W-1:0];
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_MAPPER_KIND:  prdata = 32'(mapper_kind_q);
      REG_ROM_BANK_TOT: prdata = 32'(rom_bank_total_q);
      REG_RAM_BANK_TOT: prdata = 32'(ram_bank_total_q);
      default:          prdata = 32'(ram_byte_length_q);
    endcase
  end

  assign cfg.mapper_kind     = mapper_kind_q;
  assign cfg.rom_bank_total  = rom_bank_total_q;
  assign cfg.ram_bank_total  = ram_bank_total_q;
  assign cfg.ram_byte_length = ram_byte_length_q;

  cbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  cbm_datapath #(
    .RAM_BYTES (RAM_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .command_i     (command_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .read_data_o   (read_data_o),
    .rom_address_o (rom_address_o),
    .rom_fetch_o   (rom_fetch_o)
  );

endmodule
